@@ rtl/core/deq_pkg.sv @@
// Shared types and constants for the double-ended queue.
// Used by the controller, the datapath, the top level and the port checker.
`default_nettype none

package deq_pkg;

    // Default sizing, handed to the top-level parameters.
    localparam int unsigned DEPTH_DEFAULT      = 32;
    localparam int unsigned DATA_WIDTH_DEFAULT = 32;

    // Field widths fixed by the stream interface.
    localparam int unsigned FUNC_W    = 2;
    localparam int unsigned VAL_W     = 32;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned OCC_W     = 6;
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 48;

    // Bit positions of the result fields inside m_tdata.
    localparam int unsigned M_STATUS_LSB = 32;
    localparam int unsigned M_EMPTY_BIT  = 34;
    localparam int unsigned M_FULL_BIT   = 35;
    localparam int unsigned M_OCC_LSB    = 36;

    // Operation requested by one input transaction.
    typedef enum logic [FUNC_W-1:0] {
        FN_ADD_TAIL = 2'd0,
        FN_ADD_HEAD = 2'd1,
        FN_REM_TAIL = 2'd2,
        FN_REM_HEAD = 2'd3
    } func_t;

    // Outcome reported with each result.
    typedef enum logic [STATUS_W-1:0] {
        STS_DONE       = 2'd0,
        STS_FULL_REJ   = 2'd1,
        STS_EMPTY_REJ  = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_EXEC,
        CS_RESP
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
        logic load;
    } deq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } deq_sts_t;

endpackage : deq_pkg

`default_nettype wire

@@ rtl/core/deq_ctrl.sv @@
// Controller state machine of the double-ended queue.
// Depends on deq_pkg for the state type and the command and status structs.
`default_nettype none

module deq_ctrl
    import deq_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire deq_sts_t sts,
    output deq_cmd_t      cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next-state logic: take a transaction, run it, then hand over the result.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE: begin
                if (s_tvalid) begin
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC: begin
                state_next = CS_RESP;
            end
            CS_RESP: begin
                if (sts.out_free) begin
                    state_next = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        cmd.load    = 1'b0;
        unique case (state_reg)
            CS_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            CS_EXEC: begin
                cmd.execute = 1'b1;
            end
            CS_RESP: begin
                cmd.load = sts.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule : deq_ctrl

`default_nettype wire

@@ rtl/core/deq_datapath.sv @@
// Datapath of the double-ended queue: element memory, indices, count and result register.
// Depends on deq_pkg for field widths, operation and status codes and the command structs.
`default_nettype none

module deq_datapath
    import deq_pkg::*;
#(
    parameter int unsigned DEPTH      = DEPTH_DEFAULT,
    parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,
    input  wire deq_cmd_t              cmd,
    output deq_sts_t                   sts
);

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX  = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    // Element memory, written and read at one address each.
    logic [DATA_WIDTH-1:0] mem [DEPTH];

    func_t                 op_reg;
    logic [VAL_W-1:0]      val_reg;
    logic [IW-1:0]         head_reg;
    logic [IW-1:0]         head_next;
    logic [IW-1:0]         tail_reg;
    logic [IW-1:0]         tail_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    status_t               status_reg;
    status_t               status_next;
    logic                  rm_ok_reg;
    logic                  rm_ok_next;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [IW-1:0]         rd_addr;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic [VAL_W-1:0]      value_out;
    logic                  cnt_empty;
    logic                  cnt_full;

    assign cnt_empty = (count_reg == '0);
    assign cnt_full  = (count_reg == FULL_CNT);

    // Capture the incoming transaction.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= func_t'(s_tuser);
            val_reg <= s_tdata;
        end
    end

    // Operation decode: new indices, count, status and memory access.
    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        status_next = STS_DONE;
        rm_ok_next  = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        rd_addr     = head_reg;
        unique case (op_reg) inside
            FN_ADD_TAIL, FN_ADD_HEAD: begin
                if (cnt_full) begin
                    status_next = STS_FULL_REJ;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    if (cnt_empty) begin
                        head_next = '0;
                        tail_next = '0;
                        wr_addr   = '0;
                    end else if (op_reg == FN_ADD_TAIL) begin
                        tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + IW'(1);
                        wr_addr   = tail_next;
                    end else begin
                        head_next = (head_reg == '0) ? LAST_IDX : head_reg - IW'(1);
                        wr_addr   = head_next;
                    end
                end
            end
            FN_REM_TAIL, FN_REM_HEAD: begin
                rd_addr = (op_reg == FN_REM_TAIL) ? tail_reg : head_reg;
                if (cnt_empty) begin
                    status_next = STS_EMPTY_REJ;
                end else begin
                    rm_ok_next = 1'b1;
                    count_next = count_reg - CW'(1);
                    if (count_reg == CW'(1)) begin
                        head_next = '0;
                        tail_next = '0;
                    end else if (op_reg == FN_REM_TAIL) begin
                        tail_next = (tail_reg == '0) ? LAST_IDX : tail_reg - IW'(1);
                    end else begin
                        head_next = (head_reg == LAST_IDX) ? '0 : head_reg + IW'(1);
                    end
                end
            end
            default: begin
                status_next = STS_DONE;
            end
        endcase
    end

    // Queue control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else if (cmd.execute) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Memory access and per-operation outcome.
    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            if (wr_en) begin
                mem[wr_addr] <= DATA_WIDTH'(val_reg);
            end
            rd_data_reg <= mem[rd_addr];
            status_reg  <= status_next;
            rm_ok_reg   <= rm_ok_next;
        end
    end

    // Result register towards the master side.
    assign value_out = rm_ok_reg ? VAL_W'(rd_data_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_tdata_reg <= {(M_TDATA_W - M_OCC_LSB - OCC_W)'(0), OCC_W'(count_reg),
                            cnt_full, cnt_empty, status_reg, value_out};
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;
    assign sts.out_free = !m_tvalid_reg || m_tready;

endmodule : deq_datapath

`default_nettype wire

@@ rtl/core/double_ended_queue.sv @@
// Top level of the double-ended queue: joins the controller and the datapath.
// Depends on deq_pkg, deq_ctrl and deq_datapath.
//
// Each input transaction carries an operation in s_tuser (add at tail, add at head,
// remove tail, remove head) and a value in s_tdata, and yields exactly one result
// transaction with the removed value (zero for an add or a rejection), a status, the
// empty and full flags and the occupancy after the operation. An add to a full queue
// or a removal from an empty one is rejected with a status and leaves the queue
// untouched. After the accepting edge the operation with its registered memory read
// runs in CS_EXEC, then the result register loads in CS_RESP and m_tvalid rises. The
// next transaction is accepted only after that load, so one transaction is in flight
// at a time. A result that is still held on the master side stops the next result
// from loading, and s_tready stays low until it has gone. The element memory needs
// no clearing after reset.
`default_nettype none

module double_ended_queue
    import deq_pkg::*;
#(
    parameter int unsigned DEPTH      = DEPTH_DEFAULT,
    parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] value_in
    input  wire logic [S_TUSER_W-1:0]  s_tuser,   // [1:0] func
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata    // [31:0] value_out, [33:32] status,
                                                  // [34] is_empty, [35] is_full,
                                                  // [41:36] occupancy, [47:42] zero
);

    deq_cmd_t cmd;
    deq_sts_t sts;

    // Sequencing of each transaction.
    deq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Storage, index arithmetic and result register.
    deq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule : double_ended_queue

`default_nettype wire

@@ rtl/core/deq_checker.sv @@
// Port-level assertions for the double-ended queue, bound to the top level.
// Depends on deq_pkg for the result field positions and status codes.
`default_nettype none

module deq_checker
    import deq_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // No result transaction is offered straight after reset.
    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

    // A stalled result transaction holds its contents.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // The queue is never reported both empty and full.
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[M_EMPTY_BIT] && m_tdata[M_FULL_BIT]))
        else $error("empty and full together");

    // A rejected add leaves the queue full; a rejected removal leaves it empty.
    a_reject_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            (m_tdata[M_STATUS_LSB +: STATUS_W] != STS_FULL_REJ || m_tdata[M_FULL_BIT]) &&
            (m_tdata[M_STATUS_LSB +: STATUS_W] != STS_EMPTY_REJ || m_tdata[M_EMPTY_BIT]))
        else $error("reject status disagrees with flags");

    // An empty queue reports zero occupancy, and a rejected removal reports no removed value.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[M_EMPTY_BIT] |->
            m_tdata[M_OCC_LSB +: OCC_W] == '0 &&
            (m_tdata[M_STATUS_LSB +: STATUS_W] != STS_EMPTY_REJ ||
             m_tdata[VAL_W-1:0] == '0))
        else $error("empty queue with occupancy or value");

endmodule : deq_checker

bind double_ended_queue deq_checker u_deq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
